/* sv/gdd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_pkg: shared constants and calendar tables
// Widths, reset values and month tables for the Gregorian date difference
// block and its lanes.
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int YEAR_BITS_DEF  = 12;
    localparam int MAX_YEAR_RESET = 2050;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int DAYS_W  = 21;
    localparam int DAYS_MAX = 2097151;

    // Day-of-year offset plus leap day plus day of month stays below 512
    localparam int DOY_W = 9;

    localparam int DAYS_PER_YEAR = 365;
    localparam int NUM_MONTHS    = 12;
    localparam int FEB           = 2;
    localparam int CENT_DIV      = 25;

    // x / 25 == (x * 5243) >> 17 for every x below 43690
    localparam int RECIP25     = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 17;

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/gdd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_lane: one date checker and day-number converter
// Three register stages: constant multiplies, leap test and validity with
// partial sum, final day-number add.
// ----------------------------------------------------------------------------
module gdd_lane #(
    parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic [YEAR_BITS-1:0]                     max_year,
    input  wire logic [gdd_pkg::DAY_W-1:0]                day,
    input  wire logic [gdd_pkg::MONTH_W-1:0]              month,
    input  wire logic [YEAR_BITS-1:0]                     year,
    output logic                                          ok,
    output logic [YEAR_BITS+gdd_pkg::DOY_W-1:0]           day_num
);
    import gdd_pkg::*;

    localparam int DN_W = YEAR_BITS + DOY_W;
    localparam int Q_W  = YEAR_BITS - 2;
    localparam int P_W  = Q_W + RECIP_W;
    localparam int C_W  = P_W - RECIP_SHIFT;

    // stage 1
    logic [YEAR_BITS-1:0] yr_m1;
    logic [DN_W-1:0]      y365_next, y365_reg;
    logic [Q_W-1:0]       q_next, q_reg;
    logic [Q_W-1:0]       r_next, r_reg;
    logic [P_W-1:0]       mq_next, mq_reg;
    logic [P_W-1:0]       mr_next, mr_reg;
    logic [1:0]           ylo_reg;
    logic [DAY_W-1:0]     d1_reg;
    logic [MONTH_W-1:0]   m1_reg;
    logic                 y_ok_next, y_ok_reg;

    // stage 2
    logic [C_W-1:0]       c100, c400, rd;
    logic [Q_W-1:0]       rem;
    logic                 leap;
    logic [DAY_W-1:0]     len;
    logic                 ok2_next, ok2_reg;
    logic [DN_W-1:0]      base_next, base_reg;
    logic [DOY_W-1:0]     off_next, off_reg;

    // stage 3
    logic [DN_W-1:0]      num_next, num_reg;
    logic                 ok3_reg;

    always_comb
    begin
        yr_m1     = year - YEAR_BITS'(1);
        q_next    = yr_m1[YEAR_BITS-1:2];
        r_next    = year[YEAR_BITS-1:2];
        y365_next = DN_W'(year) * DN_W'(DAYS_PER_YEAR);
        mq_next   = P_W'(q_next) * P_W'(RECIP25);
        mr_next   = P_W'(r_next) * P_W'(RECIP25);
        y_ok_next = (year != '0) && (year <= max_year);
    end

    always_ff @(posedge clk)
    begin
        y365_reg <= y365_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        mq_reg   <= mq_next;
        mr_reg   <= mr_next;
        ylo_reg  <= year[1:0];
        d1_reg   <= day;
        m1_reg   <= month;
        y_ok_reg <= y_ok_next;
    end

    always_comb
    begin
        c100 = mq_reg[P_W-1:RECIP_SHIFT];
        c400 = c100 >> 2;
        // year / 100 when the year is a multiple of 4
        rd   = mr_reg[P_W-1:RECIP_SHIFT];
        rem  = r_reg - Q_W'(Q_W'(rd) * Q_W'(CENT_DIV));
        leap = (ylo_reg == 2'd0) && ((rem != '0) || (rd[1:0] == 2'd0));
        len  = month_len(m1_reg, leap);
        // month range is checked first; the tables return zero outside it
        ok2_next = y_ok_reg && (m1_reg != '0) && (m1_reg <= MONTH_W'(NUM_MONTHS))
                   && (d1_reg != '0) && (d1_reg <= len);
        base_next = y365_reg + DN_W'(q_reg) - DN_W'(c100) + DN_W'(c400);
        off_next  = days_before(m1_reg) + DOY_W'(d1_reg)
                    + DOY_W'(leap && (m1_reg > MONTH_W'(FEB)));
    end

    always_ff @(posedge clk)
    begin
        ok2_reg  <= ok2_next;
        base_reg <= base_next;
        off_reg  <= off_next;
    end

    assign num_next = base_reg + DN_W'(off_reg);

    always_ff @(posedge clk)
    begin
        ok3_reg <= ok2_reg;
        num_reg <= num_next;
    end

    assign ok      = ok3_reg;
    assign day_num = num_reg;

endmodule

`default_nettype wire

/* sv/gdd_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_merge: combine the two lane results
// Absolute difference of the day numbers with saturation, error flag, and
// the registered result strobe.
// ----------------------------------------------------------------------------
module gdd_merge #(
    parameter int DN_W = gdd_pkg::YEAR_BITS_DEF + gdd_pkg::DOY_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          ok_a,
    input  wire logic                          ok_b,
    input  wire logic [DN_W-1:0]               num_a,
    input  wire logic [DN_W-1:0]               num_b,
    output logic                               done,
    output logic                               date_error,
    output logic [gdd_pkg::DAYS_W-1:0]         days_between
);
    import gdd_pkg::*;

    localparam int WIDE_W = (DN_W > DAYS_W) ? DN_W : DAYS_W;

    logic [DN_W-1:0]   diff;
    logic [WIDE_W-1:0] diff_wide;
    logic [DAYS_W-1:0] days_next, days_reg;
    logic              err_next, err_reg;
    logic              done_reg;

    always_comb
    begin
        diff      = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);
        diff_wide = WIDE_W'(diff);
        err_next  = !(ok_a && ok_b);
        if (err_next)
            days_next = '0;
        else if (diff_wide > WIDE_W'(DAYS_MAX))
            days_next = DAYS_W'(DAYS_MAX);
        else
            days_next = DAYS_W'(diff_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        days_reg <= days_next;
    end

    assign done         = done_reg;
    assign date_error   = err_reg;
    assign days_between = days_reg;

endmodule

`default_nettype wire

/* sv/gregorian_date_difference.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_difference: days between two Gregorian dates
// Two lanes convert the dates to day numbers in parallel; a merge stage
// forms the absolute difference or flags an invalid date.
// The done strobe for a start transfer comes through the lane stages and the merge register.
// Throughput: one date pair per cycle; busy is never raised.
// Results cannot be stalled; each is on the ports for one cycle.
// Reset clears the valid pipeline and sets max_year to 2050.
// ----------------------------------------------------------------------------
module gregorian_date_difference #(
    parameter int YEAR_BITS = gdd_pkg::YEAR_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             cfg_we,
    input  wire logic [YEAR_BITS-1:0]             cfg_wdata,
    input  wire logic [gdd_pkg::DAY_W-1:0]        day_first,
    input  wire logic [gdd_pkg::MONTH_W-1:0]      month_first,
    input  wire logic [YEAR_BITS-1:0]             year_first,
    input  wire logic [gdd_pkg::DAY_W-1:0]        day_second,
    input  wire logic [gdd_pkg::MONTH_W-1:0]      month_second,
    input  wire logic [YEAR_BITS-1:0]             year_second,
    output logic                                  done,
    output logic                                  date_error,
    output logic [gdd_pkg::DAYS_W-1:0]            days_between
);
    import gdd_pkg::*;

    localparam int DN_W = YEAR_BITS + DOY_W;
    localparam int LANE_STAGES = 3;

    logic [YEAR_BITS-1:0]   max_year_reg;
    logic [LANE_STAGES-1:0] vld_reg, vld_next;
    logic                   ok_a, ok_b;
    logic [DN_W-1:0]        num_a, num_b;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_year_reg <= YEAR_BITS'(MAX_YEAR_RESET);
        else if (cfg_we)
            max_year_reg <= cfg_wdata;
    end

    // track which lane stages hold an accepted transfer
    assign vld_next = {vld_reg[LANE_STAGES-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    gdd_lane #(.YEAR_BITS(YEAR_BITS)) u_lane_first (
        .clk      (clk),
        .max_year (max_year_reg),
        .day      (day_first),
        .month    (month_first),
        .year     (year_first),
        .ok       (ok_a),
        .day_num  (num_a)
    );

    gdd_lane #(.YEAR_BITS(YEAR_BITS)) u_lane_second (
        .clk      (clk),
        .max_year (max_year_reg),
        .day      (day_second),
        .month    (month_second),
        .year     (year_second),
        .ok       (ok_b),
        .day_num  (num_b)
    );

    gdd_merge #(.DN_W(DN_W)) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld_reg[LANE_STAGES-1]),
        .ok_a         (ok_a),
        .ok_b         (ok_b),
        .num_a        (num_a),
        .num_b        (num_b),
        .done         (done),
        .date_error   (date_error),
        .days_between (days_between)
    );

endmodule

`default_nettype wire

/* sv/gdd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_checker: port-level checks for the date difference block
// Watches transfers in and result strobes out; bound to the top level.
// ----------------------------------------------------------------------------
module gdd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [gdd_pkg::MONTH_W-1:0]   month_first,
    input  wire logic                          done,
    input  wire logic                          date_error,
    input  wire logic [gdd_pkg::DAYS_W-1:0]    days_between
);
    import gdd_pkg::*;

    localparam int LATENCY = 4;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("missing result strobe after transfer");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a transfer");

    a_error_zero_days: assert property (@(posedge clk) disable iff (!rst_n)
        (done && date_error) |-> (days_between == '0))
        else $error("error result carries nonzero days");

    a_bad_month_errors: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((month_first == '0) || (month_first > MONTH_W'(NUM_MONTHS))))
        |-> ##LATENCY (done && date_error))
        else $error("invalid month not flagged");

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .month_first  (month_first),
    .done         (done),
    .date_error   (date_error),
    .days_between (days_between)
);

`default_nettype wire
